[rtl/core/rmsm_pkg.sv]
// Shared types and constants of the block RMS meter.
`timescale 1ns / 1ps

package rmsm_pkg;

    // Result field widths, fixed by the output format.
    localparam int RMS_W   = 16;
    localparam int COUNT_W = 17;

    // Depth of the queue of closed blocks between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    // Queue status seen by both sides.
    typedef struct packed {
        logic               nonempty;
        logic [Q_LVL_W-1:0] level;
    } t_q_stat;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT,
        ST_DONE
    } t_back_state;

endpackage

[rtl/core/rmsm_queue.sv]
// Short register queue of closed-block records between front and back.
`timescale 1ns / 1ps

module rmsm_queue #(
    parameter int W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [W-1:0]          i_push_data,
    input  logic                  i_pop,
    output logic [W-1:0]          o_data,
    output rmsm_pkg::t_q_stat     o_stat
);

    localparam int PTR_W = rmsm_pkg::Q_PTR_W;
    localparam int LVL_W = rmsm_pkg::Q_LVL_W;
    localparam int DEPTH = rmsm_pkg::Q_DEPTH;

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [LVL_W-1:0] r_level;
    logic [LVL_W-1:0] n_level;

    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + 1'b1;
        end else if (!i_push && i_pop) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_level <= n_level;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_data          = r_mem[r_rd_ptr];
    assign o_stat.nonempty = (r_level != '0);
    assign o_stat.level    = r_level;

endmodule

[rtl/core/rmsm_front.sv]
// Front end: takes samples, squares them and accumulates each block.
`timescale 1ns / 1ps

module rmsm_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_BLOCK   = 65536,
    parameter int CNT_W       = 17,
    parameter int SUM_W       = 49,
    parameter int E_W         = 67
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_last,
    input  rmsm_pkg::t_q_stat      i_q_stat,
    output logic                   o_push,
    output logic [E_W-1:0]         o_push_data
);

    localparam int N      = SAMPLE_BITS;
    localparam int PEND_W = rmsm_pkg::Q_LVL_W + 1;

    logic             accept;
    logic [N-1:0]     mag;
    logic             keep;
    logic [CNT_W-1:0] cnt_after;
    logic             drop_after;
    logic [PEND_W-1:0] pending;

    // Block counters at the intake.
    logic [CNT_W-1:0] r_cnt;
    logic             r_drop;

    // Stage 1: magnitude.
    logic             r_s1_valid;
    logic             r_s1_last;
    logic             r_s1_keep;
    logic [N-1:0]     r_s1_mag;
    logic [CNT_W-1:0] r_s1_cnt;
    logic             r_s1_drop;

    // Stage 2: square.
    logic             r_s2_valid;
    logic             r_s2_last;
    logic             r_s2_keep;
    logic [2*N-1:0]   r_s2_sq;
    logic [CNT_W-1:0] r_s2_cnt;
    logic             r_s2_drop;
    logic [2*N-1:0]   n_sq;

    // Stage 3: accumulator.
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;

    // Reserve a queue slot for every block close still in the pipe.
    assign pending = PEND_W'(i_q_stat.level)
                   + PEND_W'(r_s1_valid & r_s1_last)
                   + PEND_W'(r_s2_valid & r_s2_last);
    assign o_stall = (pending >= PEND_W'(rmsm_pkg::Q_DEPTH));
    assign accept  = i_valid & ~o_stall;

    assign mag        = i_sample[N-1] ? (N'(0) - i_sample) : i_sample;
    assign keep       = (r_cnt < CNT_W'(MAX_BLOCK));
    assign cnt_after  = keep ? r_cnt + 1'b1 : r_cnt;
    assign drop_after = r_drop | ~keep;

    assign n_sq  = r_s1_mag * r_s1_mag;
    assign n_sum = r_sum + (r_s2_keep ? SUM_W'(r_s2_sq) : '0);

    assign o_push      = r_s2_valid & r_s2_last;
    assign o_push_data = {n_sum, r_s2_cnt, r_s2_drop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_drop     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_sum      <= '0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            if (accept) begin
                if (i_last) begin
                    r_cnt  <= '0;
                    r_drop <= 1'b0;
                end else begin
                    r_cnt  <= cnt_after;
                    r_drop <= drop_after;
                end
            end
            if (r_s2_valid) begin
                r_sum <= r_s2_last ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last <= i_last;
            r_s1_keep <= keep;
            r_s1_mag  <= mag;
            r_s1_cnt  <= cnt_after;
            r_s1_drop <= drop_after;
        end
        r_s2_last <= r_s1_last;
        r_s2_keep <= r_s1_keep;
        r_s2_sq   <= n_sq;
        r_s2_cnt  <= r_s1_cnt;
        r_s2_drop <= r_s1_drop;
    end

endmodule

[rtl/core/rmsm_back.sv]
// Back end: divides a closed block's sum by its count, takes the root.
`timescale 1ns / 1ps

module rmsm_back #(
    parameter int CNT_W = 17,
    parameter int SUM_W = 49,
    parameter int E_W   = 67
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rmsm_pkg::t_q_stat              i_q_stat,
    input  logic [E_W-1:0]                 i_q_data,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rmsm_pkg::RMS_W-1:0]     o_rms,
    output logic [rmsm_pkg::COUNT_W-1:0]   o_count,
    output logic                           o_overflow
);

    localparam int RMS_W   = rmsm_pkg::RMS_W;
    localparam int COUNT_W = rmsm_pkg::COUNT_W;
    localparam int SQ_W    = SUM_W + (SUM_W % 2);
    localparam int ROOT_W  = SQ_W / 2;
    localparam int IT_W    = $clog2(SUM_W);

    rmsm_pkg::t_back_state r_state;
    rmsm_pkg::t_back_state n_state;

    logic             div_step;
    logic             root_step;
    logic             out_load;
    logic             out_free;
    logic             div_last;
    logic             root_last;

    logic [SUM_W-1:0] e_sum;
    logic [CNT_W-1:0] e_cnt;
    logic             e_drop;

    logic [IT_W-1:0]  r_iter;
    logic [SUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_drop;
    logic [SQ_W-1:0]  r_x;
    logic [ROOT_W-1:0] r_root;
    // Root remainder can reach twice the partial root, one bit wider.
    logic [ROOT_W:0]   r_rrem;
    logic             r_out_valid;

    logic [CNT_W:0]   rem_sh;
    logic             div_ge;
    logic [CNT_W:0]   rem_sub;
    logic [SUM_W-1:0] n_quo;
    logic [ROOT_W+2:0] rrem_sh;
    logic [ROOT_W+2:0] trial;
    logic             root_ge;
    logic [ROOT_W+2:0] rrem_sub;

    assign {e_sum, e_cnt, e_drop} = i_q_data;

    assign out_free  = ~r_out_valid | ~i_stall;
    assign div_last  = (r_iter == IT_W'(SUM_W - 1));
    assign root_last = (r_iter == IT_W'(ROOT_W - 1));

    // Restoring divide, one quotient bit per cycle; a zero divisor yields zero.
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_div}) && (r_div != '0);
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign n_quo   = {r_quo[SUM_W-2:0], div_ge};

    // Digit-by-digit root, one result bit per cycle.
    assign rrem_sh  = {r_rrem, r_x[SQ_W-1:SQ_W-2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign root_ge  = (rrem_sh >= trial);
    assign rrem_sub = rrem_sh - trial;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmsm_pkg::ST_IDLE: begin
                if (i_q_stat.nonempty) begin
                    n_state = rmsm_pkg::ST_DIV;
                end
            end
            rmsm_pkg::ST_DIV: begin
                if (div_last) begin
                    n_state = rmsm_pkg::ST_ROOT;
                end
            end
            rmsm_pkg::ST_ROOT: begin
                if (root_last) begin
                    n_state = rmsm_pkg::ST_DONE;
                end
            end
            rmsm_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = rmsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        div_step  = 1'b0;
        root_step = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            rmsm_pkg::ST_IDLE: o_pop     = i_q_stat.nonempty;
            rmsm_pkg::ST_DIV:  div_step  = 1'b1;
            rmsm_pkg::ST_ROOT: root_step = 1'b1;
            rmsm_pkg::ST_DONE: out_load  = out_free;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmsm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quo  <= e_sum;
            r_rem  <= '0;
            r_div  <= e_cnt;
            r_cnt  <= e_cnt;
            r_drop <= e_drop;
            r_iter <= '0;
        end
        if (div_step) begin
            r_quo <= n_quo;
            r_rem <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            if (div_last) begin
                r_x    <= SQ_W'(n_quo);
                r_root <= '0;
                r_rrem <= '0;
                r_iter <= '0;
            end else begin
                r_iter <= r_iter + 1'b1;
            end
        end
        if (root_step) begin
            r_x    <= {r_x[SQ_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], root_ge};
            r_rrem <= root_ge ? rrem_sub[ROOT_W:0] : rrem_sh[ROOT_W:0];
            r_iter <= r_iter + 1'b1;
        end
        if (out_load) begin
            o_rms      <= RMS_W'(r_root);
            o_count    <= COUNT_W'(r_cnt);
            o_overflow <= r_drop;
        end
    end

    assign o_valid = r_out_valid;

endmodule

[rtl/core/block_rms_meter.sv]
// Top level of the block RMS meter.
`timescale 1ns / 1ps

// Block RMS meter. Signed samples enter at up to one item per cycle; each is
// squared exactly and added to a wide accumulator, and the samples of the
// block are counted. The item marked last closes the block and yields one
// result: rms = floor(sqrt(floor(sum / count))), unsigned Q1.15 for Q1.15
// samples, with the count and an overflow flag. Samples that arrive once
// MAX_BLOCK have been counted are dropped (the last one still closes the
// block) and the flag is raised. The intake runs three stages (magnitude,
// square, accumulate) and hands each closed block to a two-entry queue. The
// back end serves one closed block at a time: a restoring divider gives one
// quotient bit per cycle and a digit-by-digit root one result bit per cycle,
// with SUM_W = min(64, 2*SAMPLE_BITS + clog2(MAX_BLOCK+1)) quotient bits
// and ROOT_W = ceil(SUM_W/2) root bits. Samples stream at one per cycle
// as long as the back end keeps up with the blocks; a run of short blocks
// fills the queue and raises o_stall until the back end catches up. The
// result waits in an output register while the next block is being
// measured. Sums wider than 64 bits wrap modulo 2^64 and the reported
// count wraps modulo 2^17.

module block_rms_meter #(
    parameter int MAX_BLOCK   = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Sample channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_last,
    // Result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [rmsm_pkg::RMS_W-1:0]        o_rms,
    output logic [rmsm_pkg::COUNT_W-1:0]      o_count,
    output logic                              o_overflow
);

    // Count must reach MAX_BLOCK itself.
    localparam int CNT_W   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK + 1) : 1;
    // Sum of squares, capped at 64 bits where it wraps.
    localparam int SUM_RAW = 2 * SAMPLE_BITS + CNT_W;
    localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
    // Closed-block record: sum, count, drop flag.
    localparam int E_W     = SUM_W + CNT_W + 1;

    rmsm_pkg::t_q_stat q_stat;
    logic              q_push;
    logic [E_W-1:0]    q_push_data;
    logic              q_pop;
    logic [E_W-1:0]    q_data;

    // Intake: magnitude, square and accumulate; push a record per block.
    rmsm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_BLOCK   (MAX_BLOCK),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .E_W         (E_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // Decouple the sample stream from the slow per-block arithmetic.
    rmsm_queue #(
        .W           (E_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_data      (q_data),
        .o_stat      (q_stat)
    );

    // Divide and root, then hold the result until it is taken.
    rmsm_back #(
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .E_W         (E_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_q_data    (q_data),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rms       (o_rms),
        .o_count     (o_count),
        .o_overflow  (o_overflow)
    );

endmodule
